### rtl/ftt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ftt_pkg;

  localparam int ENTRIES_DEFAULT = 4096;
  localparam int WAYS_DEFAULT    = 4;
  localparam int HASH_W          = 16;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [4:0] FLAG_FIN = 5'h01;
  localparam logic [4:0] FLAG_SYN = 5'h02;
  localparam logic [4:0] FLAG_RST = 5'h04;
  localparam logic [4:0] FLAG_ACK = 5'h10;

  typedef enum logic [2:0] {
    ST_IGNORED      = 3'd0,
    ST_CREATED      = 3'd1,
    ST_CREATED_EVICT = 3'd2,
    ST_UPDATED      = 3'd3,
    ST_EGRESS_MISS  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } back_state_t;

  // Classified request as it travels from the front end to the table engine.
  typedef struct packed {
    logic              ignore;
    logic              egress;
    logic [63:0]       kaddr;
    logic [39:0]       kpp;
    logic              term;
    logic              new_tcp;
    logic [15:0]       len;
    logic [63:0]       now;
    logic [HASH_W-1:0] set;
  } qitem_t;

  typedef struct packed {
    logic        valid;
    logic        ended;
    logic [63:0] kaddr;
    logic [39:0] kpp;
    logic [63:0] start;
    logic [63:0] last;
    logic [63:0] txb;
    logic [63:0] rxb;
    logic [63:0] txp;
    logic [63:0] rxp;
  } entry_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] flow_start;
    logic [63:0] flow_last;
    logic [63:0] sent_bytes;
    logic [63:0] received_bytes;
    logic [63:0] sent_packets;
    logic [63:0] received_packets;
    logic        flow_ended;
  } result_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

`default_nettype wire

### rtl/ftt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ftt_pkt_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic        header_ok;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [7:0]  protocol_number;
  logic [4:0]  flag_bits;
  logic [15:0] packet_length;
  logic [63:0] timestamp;

  modport source (output valid, opcode, header_ok, source_address, dest_address,
                  source_port, dest_port, protocol_number, flag_bits, packet_length,
                  timestamp, input ready);
  modport sink (input valid, opcode, header_ok, source_address, dest_address,
                source_port, dest_port, protocol_number, flag_bits, packet_length,
                timestamp, output ready);
endinterface

interface ftt_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] flow_start;
  logic [63:0] flow_last;
  logic [63:0] sent_bytes;
  logic [63:0] received_bytes;
  logic [63:0] sent_packets;
  logic [63:0] received_packets;
  logic        flow_ended;

  modport source (output valid, status, flow_start, flow_last, sent_bytes,
                  received_bytes, sent_packets, received_packets, flow_ended,
                  input ready);
  modport sink (input valid, status, flow_start, flow_last, sent_bytes,
                received_bytes, sent_packets, received_packets, flow_ended,
                output ready);
endinterface

`default_nettype wire

### rtl/flow_tuple_table_tracker_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake      Carries
// pkt      in   valid/ready    direction, 5-tuple, flags, length, time, parse status
// res      out  valid/ready    status, flow times, byte and packet counters, ended
//
// A request's set row is read from the table memory as it is popped in IDLE;
// EXEC compares, updates and writes it back. No request is popped until the
// last one is through. When ENTRIES/WAYS is not a power of two, the front end
// first forms the set index as a remainder of the hash. After reset a clearing
// pass writes every set row while pkt.ready is low. A stalled result holds in
// its register while the front end and a two-deep queue keep taking requests.

module flow_tuple_table_tracker_core #(
  parameter int ENTRIES = ftt_pkg::ENTRIES_DEFAULT,
  parameter int WAYS    = ftt_pkg::WAYS_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  ftt_pkt_if.sink  pkt,
  ftt_res_if.source res
);

  localparam int SETS = ENTRIES / WAYS;

  ftt_pkg::back_status_t bstat;
  ftt_pkg::qitem_t       push_item;
  ftt_pkg::qitem_t       q_head;
  logic                  push;
  logic                  q_full;
  logic                  q_valid;
  logic                  pop;

  ftt_front #(.SETS(SETS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .pkt       (pkt),
    .bstat     (bstat),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  ftt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  ftt_back #(.SETS(SETS), .WAYS(WAYS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .bstat   (bstat),
    .res     (res)
  );

endmodule

`default_nettype wire

### rtl/ftt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ftt_front #(
  parameter int SETS = ftt_pkg::ENTRIES_DEFAULT / ftt_pkg::WAYS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  ftt_pkt_if.sink                    pkt,
  input  wire ftt_pkg::back_status_t bstat,
  input  wire logic                  q_full,
  output logic                       push,
  output ftt_pkg::qitem_t            push_item
);

  localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam bit SETS_POW2 = ((SETS & (SETS - 1)) == 0);
  localparam int BITS_STEP = 8;
  localparam int STEPS     = SETS_POW2 ? 0 : ftt_pkg::HASH_W / BITS_STEP;
  localparam int CNT_W     = 2;
  localparam int REM_W     = SET_W + 1;

  ftt_pkg::qitem_t            hold;
  logic                       hold_valid;
  logic [ftt_pkg::HASH_W-1:0] dvd;
  logic [REM_W-1:0]           rem;
  logic [CNT_W-1:0]           cnt;

  ftt_pkg::qitem_t            cls;
  logic [ftt_pkg::HASH_W-1:0] hash;
  logic [ftt_pkg::HASH_W-1:0] dvd_next;
  logic [REM_W-1:0]           rem_next;
  logic                       accept;

  always_comb begin
    logic        tcp;
    logic        udp;
    logic [4:0]  flg;
    logic [31:0] ksa;
    logic [31:0] kda;
    logic [15:0] ksp;
    logic [15:0] kdp;
    logic [31:0] h32;
    tcp = (pkt.protocol_number == ftt_pkg::PROTO_TCP);
    udp = (pkt.protocol_number == ftt_pkg::PROTO_UDP);
    flg = udp ? 5'd0 : pkt.flag_bits;
    if (pkt.opcode) begin
      ksa = pkt.dest_address;
      kda = pkt.source_address;
      ksp = pkt.dest_port;
      kdp = pkt.source_port;
    end else begin
      ksa = pkt.source_address;
      kda = pkt.dest_address;
      ksp = pkt.source_port;
      kdp = pkt.dest_port;
    end
    h32 = ksa ^ kda ^ {ksp, kdp} ^ {24'd0, pkt.protocol_number};
    hash = h32[31:16] ^ h32[15:0];
    cls.ignore  = !pkt.header_ok || !(tcp || udp);
    cls.egress  = pkt.opcode;
    cls.kaddr   = {ksa, kda};
    cls.kpp     = {ksp, kdp, pkt.protocol_number};
    cls.term    = |(flg & (ftt_pkg::FLAG_FIN | ftt_pkg::FLAG_RST));
    cls.new_tcp = tcp && |(flg & ftt_pkg::FLAG_SYN) && !(|(flg & ftt_pkg::FLAG_ACK));
    cls.len     = pkt.packet_length;
    cls.now     = pkt.timestamp;
    cls.set     = hash;
  end

  // Restoring remainder by the set count, a byte of the hash per cycle.
  always_comb begin
    logic [REM_W-1:0]           r;
    logic [ftt_pkg::HASH_W-1:0] d;
    r = rem;
    d = dvd;
    for (int i = 0; i < BITS_STEP; i++) begin
      r = {r[REM_W-2:0], d[ftt_pkg::HASH_W-1]};
      d = {d[ftt_pkg::HASH_W-2:0], 1'b0};
      if (r >= REM_W'(SETS)) begin
        r = r - REM_W'(SETS);
      end
    end
    rem_next = r;
    dvd_next = d;
  end

  assign push   = hold_valid && (cnt == '0) && !q_full;
  assign pkt.ready = !bstat.clearing && (!hold_valid || push);
  assign accept = pkt.valid && pkt.ready;

  always_comb begin
    push_item = hold;
    if (SETS_POW2) begin
      push_item.set = ftt_pkg::HASH_W'(hold.set[SET_W-1:0]);
    end else begin
      push_item.set = ftt_pkg::HASH_W'(rem[SET_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      cnt        <= '0;
    end else if (accept) begin
      hold_valid <= 1'b1;
      cnt        <= CNT_W'(STEPS);
    end else begin
      if (push) begin
        hold_valid <= 1'b0;
      end
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold     <= cls;
      dvd      <= hash;
      rem      <= '0;
    end else if (cnt != '0) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire

### rtl/ftt_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ftt_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire ftt_pkg::qitem_t push_item,
  output logic                 full,
  input  wire logic            pop,
  output logic                 head_valid,
  output ftt_pkg::qitem_t      head
);

  ftt_pkg::qitem_t slot [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) |-> !(push && !pop))
    else $error("request queue overflow");

endmodule

`default_nettype wire

### rtl/ftt_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ftt_back #(
  parameter int SETS = ftt_pkg::ENTRIES_DEFAULT / ftt_pkg::WAYS_DEFAULT,
  parameter int WAYS = ftt_pkg::WAYS_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire ftt_pkg::qitem_t q_head,
  output logic                 pop,
  output ftt_pkg::back_status_t bstat,
  ftt_res_if.source            res
);

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef struct packed {
    ftt_pkg::entry_t [WAYS-1:0]            ent;
    logic            [WAYS-1:0][WAY_W-1:0] lru;
  } row_t;

  row_t                 mem [SETS];
  row_t                 rd_row;
  row_t                 new_row;
  row_t                 clear_row;
  row_t                 wr_row;
  logic [SET_W-1:0]     wr_addr;
  logic                 we;
  logic                 out_load;
  logic                 do_write;

  ftt_pkg::back_state_t state;
  ftt_pkg::back_state_t state_next;
  logic [SET_W-1:0]     clr_cnt;
  ftt_pkg::qitem_t      cur;
  ftt_pkg::result_t     res_q;
  ftt_pkg::result_t     res_next;
  logic                 res_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      ftt_pkg::BK_CLEAR: begin
        if (clr_cnt == SET_W'(SETS - 1)) begin
          state_next = ftt_pkg::BK_IDLE;
        end
      end
      ftt_pkg::BK_IDLE: begin
        if (q_valid) begin
          state_next = ftt_pkg::BK_EXEC;
        end
      end
      ftt_pkg::BK_EXEC: begin
        if (!res_valid || res.ready) begin
          state_next = ftt_pkg::BK_IDLE;
        end
      end
      default: state_next = ftt_pkg::BK_CLEAR;
    endcase
  end

  always_comb begin
    pop            = (state == ftt_pkg::BK_IDLE) && q_valid;
    out_load       = (state == ftt_pkg::BK_EXEC) && (!res_valid || res.ready);
    bstat.clearing = (state == ftt_pkg::BK_CLEAR);
    we             = bstat.clearing || (out_load && do_write);
    wr_addr        = bstat.clearing ? clr_cnt : cur.set[SET_W-1:0];
    wr_row         = bstat.clearing ? clear_row : new_row;
  end

  always_comb begin
    clear_row = '0;
    for (int i = 0; i < WAYS; i++) begin
      clear_row.lru[i] = WAY_W'(i);
    end
  end

  // Lookup, victim choice, counter update and recency for the set just read.
  always_comb begin
    logic            hit;
    logic [WAY_W-1:0] hit_idx;
    logic            inv_found;
    logic [WAY_W-1:0] inv_idx;
    logic            create;
    logic [WAY_W-1:0] sel;
    logic [WAY_W-1:0] pos;
    ftt_pkg::entry_t old_e;
    ftt_pkg::entry_t upd;
    ftt_pkg::status_t st;
    hit       = 1'b0;
    hit_idx   = '0;
    inv_found = 1'b0;
    inv_idx   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_row.ent[w].valid && rd_row.ent[w].kaddr == cur.kaddr &&
          rd_row.ent[w].kpp == cur.kpp) begin
        hit     = 1'b1;
        hit_idx = WAY_W'(w);
      end
      if (!rd_row.ent[w].valid) begin
        inv_found = 1'b1;
        inv_idx   = WAY_W'(w);
      end
    end
    create = !cur.egress && (!hit || cur.new_tcp);
    if (hit) begin
      sel = hit_idx;
    end else if (inv_found) begin
      sel = inv_idx;
    end else begin
      sel = rd_row.lru[0];
    end
    old_e = rd_row.ent[sel];
    upd   = old_e;
    if (create) begin
      upd.valid = 1'b1;
      upd.kaddr = cur.kaddr;
      upd.kpp   = cur.kpp;
      upd.start = cur.now;
      upd.last  = cur.now;
      upd.txb   = 64'(cur.len);
      upd.rxb   = '0;
      upd.txp   = 64'd1;
      upd.rxp   = '0;
      upd.ended = cur.term;
      st = (hit || inv_found) ? ftt_pkg::ST_CREATED : ftt_pkg::ST_CREATED_EVICT;
    end else begin
      upd.last  = cur.now;
      if (cur.egress) begin
        upd.rxb = old_e.rxb + 64'(cur.len);
        upd.rxp = old_e.rxp + 64'd1;
      end else begin
        upd.txb = old_e.txb + 64'(cur.len);
        upd.txp = old_e.txp + 64'd1;
      end
      upd.ended = old_e.ended | cur.term;
      st = ftt_pkg::ST_UPDATED;
    end

    pos = WAY_W'(WAYS - 1);
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (rd_row.lru[i] == sel) begin
        pos = WAY_W'(i);
      end
    end
    new_row = rd_row;
    new_row.ent[sel] = upd;
    for (int i = 0; i < WAYS - 1; i++) begin
      if (WAY_W'(i) >= pos) begin
        new_row.lru[i] = rd_row.lru[i + 1];
      end
    end
    new_row.lru[WAYS-1] = sel;

    do_write = !cur.ignore && !(cur.egress && !hit);
    res_next = '0;
    if (cur.ignore) begin
      res_next.status = ftt_pkg::ST_IGNORED;
    end else if (cur.egress && !hit) begin
      res_next.status = ftt_pkg::ST_EGRESS_MISS;
    end else begin
      res_next.status           = st;
      res_next.flow_start       = upd.start;
      res_next.flow_last        = upd.last;
      res_next.sent_bytes       = upd.txb;
      res_next.received_bytes   = upd.rxb;
      res_next.sent_packets     = upd.txp;
      res_next.received_packets = upd.rxp;
      res_next.flow_ended       = upd.ended;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_row <= mem[q_head.set[SET_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ftt_pkg::BK_CLEAR;
      clr_cnt   <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (bstat.clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
    if (out_load) begin
      res_q <= res_next;
    end
  end

  assign res.valid            = res_valid;
  assign res.status           = res_q.status;
  assign res.flow_start       = res_q.flow_start;
  assign res.flow_last        = res_q.flow_last;
  assign res.sent_bytes       = res_q.sent_bytes;
  assign res.received_bytes   = res_q.received_bytes;
  assign res.sent_packets     = res_q.sent_packets;
  assign res.received_packets = res_q.received_packets;
  assign res.flow_ended       = res_q.flow_ended;

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!res_valid || res.ready))
    else $error("result overwritten before it was taken");

  a_pop_exec: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == ftt_pkg::BK_EXEC))
    else $error("popped request did not reach execute");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    bstat.clearing |-> !pop && !out_load)
    else $error("request handled during table clear");

endmodule

`default_nettype wire
